FILE: rtl/hcdc_pkg.sv
// Package with types, constants and the CRC byte function of the header check block.
`timescale 1ns / 1ps

package hcdc_pkg;

  localparam logic [3:0]  HDR_LEN       = 4'd6;
  localparam logic [3:0]  PAYLOAD_START = 4'd14;
  localparam logic [7:0]  DECODE_BIAS   = 8'h15;
  localparam logic [2:0]  PHASE_LAST    = 3'd5;
  localparam logic [31:0] CRC_POLY      = 32'hDB71_0641;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_HEADER   = 2'd0,
    KIND_CRC_TEXT = 2'd1,
    KIND_PAYLOAD  = 2'd2
  } byte_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_SHORT      = 2'd1,
    STATUS_BAD_HEADER = 2'd2
  } blob_status_t;

  // One classified byte on its way from the front to the back.
  typedef struct packed {
    logic [7:0]   data;
    byte_kind_t   kind;
    blob_status_t status;
    logic         fin;
  } hcdc_entry_t;

  // ASCII magic "DGDATA", one character per header position.
  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h44;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h44;
      3'd3:    c = 8'h41;
      3'd4:    c = 8'h54;
      3'd5:    c = 8'h41;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Reflected CRC update over one byte; the shift keeps bit 31.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] d);
    logic [31:0] v;
    v = {24'h0, d ^ crc[7:0]};
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = v ^ CRC_POLY;
      end
      v = {v[31], v[31:1]};
    end
    return {8'h00, crc[31:8]} ^ v;
  endfunction

endpackage

FILE: rtl/hcdc_if.sv
// Valid/ready channel interfaces for input bytes and result items.
`timescale 1ns / 1ps

interface hcdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

interface hcdc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  byte_kind;
  logic [31:0] crc_value;
  logic [1:0]  blob_status;
  logic        end_mark;

  modport source (output valid, output out_byte, output byte_kind, output crc_value,
                  output blob_status, output end_mark, input ready);
  modport sink   (input valid, input out_byte, input byte_kind, input crc_value,
                  input blob_status, input end_mark, output ready);
endinterface

FILE: rtl/header_check_deobfuscate_crc_core.sv
// Top level of the blob header check, payload decode and CRC block.
//
//   channel  direction  transaction
//   in_ch    sink       in_byte, is_final
//   out_ch   source     out_byte, byte_kind, crc_value, blob_status, end_mark
//
// One byte per cycle is accepted while the queue is not full, and one result per byte is given, in order.
// An accepted byte is written into a queue slot before it reaches the result register;
// the CRC byte update in the back end sets the clock path.
// Synchronous active-low reset empties the queue and clears all blob state.
// A two-entry queue parts the front from the back, so a stalled output holds
// results while input keeps flowing until the queue fills.
`timescale 1ns / 1ps

module header_check_deobfuscate_crc_core (
  input  logic       clk,
  input  logic       rst_n,
  hcdc_in_if.sink    in_ch,
  hcdc_out_if.source out_ch
);
  import hcdc_pkg::*;

  logic        push, q_full, q_valid, pop;
  hcdc_entry_t push_entry, q_entry;

  hcdc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.in_byte),
    .is_final   (in_ch.is_final),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  hcdc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .q_valid    (q_valid),
    .pop        (pop),
    .q_entry    (q_entry)
  );

  hcdc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: rtl/hcdc_front.sv
// Front end: tracks blob position, checks the magic, decodes payload bytes.
`timescale 1ns / 1ps

module hcdc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               is_final,
  output logic               push,
  output hcdc_pkg::hcdc_entry_t push_entry,
  input  logic               q_full
);
  import hcdc_pkg::*;

  logic [3:0] position_r, position_nxt;
  logic       magic_ok_r, magic_ok_nxt;
  logic [2:0] phase_r, phase_nxt;

  logic       is_header, is_text, mismatch, magic_now;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    is_header = position_r < HDR_LEN;
    is_text   = !is_header && (position_r < PAYLOAD_START);
    mismatch  = in_byte != magic_char(position_r[2:0]);
    magic_now = magic_ok_r && !(is_header && mismatch);

    push_entry.fin    = is_final;
    push_entry.status = STATUS_OK;
    if (is_header) begin
      push_entry.data = in_byte;
      push_entry.kind = KIND_HEADER;
    end else if (is_text) begin
      push_entry.data = in_byte;
      push_entry.kind = KIND_CRC_TEXT;
    end else begin
      push_entry.data = in_byte - DECODE_BIAS - {5'b0, phase_r};
      push_entry.kind = KIND_PAYLOAD;
    end
    if (is_final) begin
      // A short blob wins over a header mismatch.
      if (position_r < PAYLOAD_START - 4'd1) begin
        push_entry.status = STATUS_SHORT;
      end else if (!magic_now) begin
        push_entry.status = STATUS_BAD_HEADER;
      end
    end
  end

  always_comb begin
    position_nxt = position_r;
    magic_ok_nxt = magic_ok_r;
    phase_nxt    = phase_r;
    if (push) begin
      if (is_final) begin
        position_nxt = 4'd0;
        magic_ok_nxt = 1'b1;
        phase_nxt    = 3'd0;
      end else begin
        magic_ok_nxt = magic_now;
        if (position_r < PAYLOAD_START) begin
          position_nxt = position_r + 4'd1;
        end else begin
          phase_nxt = (phase_r >= PHASE_LAST) ? 3'd0 : phase_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= 4'd0;
      magic_ok_r <= 1'b1;
      phase_r    <= 3'd0;
    end else begin
      position_r <= position_nxt;
      magic_ok_r <= magic_ok_nxt;
      phase_r    <= phase_nxt;
    end
  end

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    position_r <= PAYLOAD_START && phase_r <= PHASE_LAST)
    else $error("front position or phase out of range");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push && is_final |=> position_r == 4'd0 && magic_ok_r && phase_r == 3'd0)
    else $error("front state not cleared after final byte");

endmodule

FILE: rtl/hcdc_queue.sv
// Two-entry queue between the front end and the CRC back end.
`timescale 1ns / 1ps

module hcdc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  hcdc_pkg::hcdc_entry_t push_entry,
  output logic                  full,
  output logic                  q_valid,
  input  logic                  pop,
  output hcdc_pkg::hcdc_entry_t q_entry
);
  import hcdc_pkg::*;

  hcdc_entry_t       slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full    = count_r == QCNT_W'(QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign q_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: rtl/hcdc_back.sv
// Back end: runs the CRC over decoded payload bytes and holds the result register.
`timescale 1ns / 1ps

module hcdc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  hcdc_pkg::hcdc_entry_t q_entry,
  output logic                  pop,
  hcdc_out_if.source            out_ch
);
  import hcdc_pkg::*;

  logic [31:0]  crc_r, crc_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   out_byte_r;
  byte_kind_t   kind_r;
  logic [31:0]  crc_out_r;
  blob_status_t status_r;
  logic         end_r;

  // The result register is refilled in the same cycle that it is taken.
  assign pop = q_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    crc_nxt = crc_r;
    if (q_entry.kind == KIND_PAYLOAD) begin
      crc_nxt = crc_byte(crc_r, q_entry.data);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= 32'h0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        crc_r <= q_entry.fin ? 32'h0 : crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte_r <= q_entry.data;
      kind_r     <= q_entry.kind;
      crc_out_r  <= crc_nxt;
      status_r   <= q_entry.status;
      end_r      <= q_entry.fin;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.byte_kind   = kind_r;
  assign out_ch.crc_value   = crc_out_r;
  assign out_ch.blob_status = status_r;
  assign out_ch.end_mark    = end_r;

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !end_r |-> status_r == STATUS_OK)
    else $error("status reported before the final byte");

  a_crc_zero_before_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r != KIND_PAYLOAD |-> crc_out_r == 32'h0)
    else $error("nonzero CRC on a header or CRC text byte");

  a_crc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    pop && q_entry.fin |=> crc_r == 32'h0)
    else $error("CRC not cleared after final byte");

endmodule

FILE: tb/header_check_deobfuscate_crc_core_test.sv
// Testbench for the blob header check, payload decode and CRC block.
`timescale 1ns / 1ps

module header_check_deobfuscate_crc_core_test;
  import hcdc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } raw_byte_t;

  typedef struct {
    logic [7:0]   data;
    byte_kind_t   kind;
    logic [31:0]  crc;
    blob_status_t status;
    logic         fin;
  } blob_result_t;

  typedef enum int {
    HDR_GOOD,
    HDR_ONE_BAD,
    HDR_NOISE
  } hdr_style_t;

  localparam int ITEMS_PER_PHASE = 130;
  localparam int DRAIN_CYCLES    = 20;

  logic clk;
  logic rst_n;

  hcdc_in_if  in_ch ();
  hcdc_out_if out_ch ();

  header_check_deobfuscate_crc_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  logic [7:0] magic_seq [0:5] = '{8'h44, 8'h47, 8'h44, 8'h41, 8'h54, 8'h41};

  raw_byte_t    raw_feed[$];
  blob_result_t blob_results[$];
  int           mismatch_count;
  int           idle_pct;
  int           stall_pct;
  bit           in_taken;
  raw_byte_t    next_byte;

  // Blob tracking state of the predictor.
  logic [3:0]  blob_pos;
  logic        magic_match;
  logic [2:0]  payload_phase;
  logic [31:0] blob_crc;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc, input logic [7:0] d);
    logic [31:0] v;
    v = {24'h0, d ^ crc[7:0]};
    repeat (8) begin
      if (v[0]) begin
        v = v ^ CRC_POLY;
      end
      v = $unsigned($signed(v) >>> 1);
    end
    return (crc >> 8) ^ v;
  endfunction

  task automatic clear_blob_state();
    blob_pos      = 4'd0;
    magic_match   = 1'b1;
    payload_phase = 3'd0;
    blob_crc      = 32'h0;
  endtask

  task automatic predict_blob_byte(input logic [7:0] b, input logic fin);
    blob_result_t r;
    r.data   = b;
    r.status = STATUS_OK;
    r.fin    = fin;
    if (blob_pos < HDR_LEN) begin
      if (b != magic_seq[blob_pos]) begin
        magic_match = 1'b0;
      end
      r.kind = KIND_HEADER;
    end else if (blob_pos < PAYLOAD_START) begin
      r.kind = KIND_CRC_TEXT;
    end else begin
      r.data        = b - DECODE_BIAS - {5'd0, payload_phase};
      r.kind        = KIND_PAYLOAD;
      blob_crc      = crc_fold_byte(blob_crc, r.data);
      payload_phase = (payload_phase == 3'd5) ? 3'd0 : payload_phase + 3'd1;
    end
    r.crc = blob_crc;
    if (fin) begin
      // A short blob wins over a header mismatch.
      if (int'(blob_pos) + 1 < int'(PAYLOAD_START)) begin
        r.status = STATUS_SHORT;
      end else if (!magic_match) begin
        r.status = STATUS_BAD_HEADER;
      end
    end
    blob_results.push_back(r);
    if (blob_pos < PAYLOAD_START) begin
      blob_pos = blob_pos + 4'd1;
    end
    if (fin) begin
      clear_blob_state();
    end
  endtask

  task automatic queue_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) begin
      raw_feed.push_back('{data: seq[i], fin: (i == seq.size() - 1)});
    end
  endtask

  task automatic queue_random_blob(output int len);
    hdr_style_t style;
    int         sel;
    int         bad_idx;
    int         nib;
    logic [7:0] b;
    sel = $urandom_range(99);
    if (sel < 10) begin
      len = $urandom_range(13, 1);
    end else if (sel < 20) begin
      len = 14;
    end else if (sel < 35) begin
      len = $urandom_range(20, 15);
    end else begin
      len = $urandom_range(60, 15);
    end
    sel = $urandom_range(99);
    style = (sel < 75) ? HDR_GOOD : (sel < 88) ? HDR_ONE_BAD : HDR_NOISE;
    bad_idx = $urandom_range(5);
    for (int i = 0; i < len; i++) begin
      if (i < 6) begin
        case (style)
          HDR_GOOD: begin
            b = magic_seq[i];
          end
          HDR_ONE_BAD: begin
            b = (i == bad_idx) ? magic_seq[i] ^ 8'($urandom_range(255, 1)) : magic_seq[i];
          end
          default: begin
            b = 8'($urandom_range(255));
          end
        endcase
      end else if (i < 14) begin
        // Stored CRC text is mostly hex characters, sometimes any byte.
        nib = $urandom_range(15);
        if ($urandom_range(3) != 0) begin
          b = (nib < 10) ? 8'(8'h30 + nib) : 8'(8'h41 + nib - 10);
        end else begin
          b = 8'($urandom_range(255));
        end
      end else begin
        b = 8'($urandom_range(255));
      end
      raw_feed.push_back('{data: b, fin: (i == len - 1)});
    end
  endtask

  task automatic wait_drained();
    while (raw_feed.size() != 0 || in_ch.valid || blob_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Input acceptance and prediction.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_blob_byte(in_ch.in_byte, in_ch.is_final);
      in_taken = 1'b1;
    end
  end

  // Byte driver.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.in_byte  <= 8'h00;
      in_ch.is_final <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      in_taken = 1'b0;
      if (raw_feed.size() > 0 && $urandom_range(99) >= idle_pct) begin
        next_byte = raw_feed.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= next_byte.data;
        in_ch.is_final <= next_byte.fin;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver.
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // Result monitor.
  always @(posedge clk) begin
    blob_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (blob_results.size() == 0) begin
        $error("result transaction with no expectation: out_byte %0h", out_ch.out_byte);
        mismatch_count++;
      end else begin
        want = blob_results.pop_front();
        if (out_ch.out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_ch.out_byte);
          mismatch_count++;
        end
        if (out_ch.byte_kind !== want.kind) begin
          $error("byte_kind: expected %0d, got %0d", want.kind, out_ch.byte_kind);
          mismatch_count++;
        end
        if (out_ch.crc_value !== want.crc) begin
          $error("crc_value: expected %08h, got %08h", want.crc, out_ch.crc_value);
          mismatch_count++;
        end
        if (out_ch.blob_status !== want.status) begin
          $error("blob_status: expected %0d, got %0d", want.status, out_ch.blob_status);
          mismatch_count++;
        end
        if (out_ch.end_mark !== want.fin) begin
          $error("end_mark: expected %0b, got %0b", want.fin, out_ch.end_mark);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int queued;
    int len;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = 8'h00;
    in_ch.is_final = 1'b0;
    out_ch.ready   = 1'b0;
    rst_n          = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    in_taken       = 1'b0;
    mismatch_count = 0;
    clear_blob_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Well-formed blob with payload bytes at both extremes.
    queue_bytes('{8'h44, 8'h47, 8'h44, 8'h41, 8'h54, 8'h41,
                  8'h30, 8'h31, 8'h32, 8'h33, 8'h41, 8'h42, 8'h43, 8'h44,
                  8'h00, 8'hFF});
    // One-byte blob ends too short.
    queue_bytes('{8'h00});
    // A wrong header that also ends too short reports the short status.
    queue_bytes('{8'h44, 8'h47, 8'h44, 8'h41, 8'h54, 8'h42});

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      queued = 0;
      while (queued < ITEMS_PER_PHASE) begin
        queue_random_blob(len);
        queued += len;
      end
      // The sender holds off here until every outstanding result has come back.
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (blob_results.size() != 0) begin
      $error("%0d expected results never arrived", blob_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: header_check_deobfuscate_crc_core.f
rtl/hcdc_pkg.sv
rtl/hcdc_if.sv
rtl/hcdc_front.sv
rtl/hcdc_queue.sv
rtl/hcdc_back.sv
rtl/header_check_deobfuscate_crc_core.sv
tb/header_check_deobfuscate_crc_core_test.sv
